>>> rtl/bcpc_pkg.sv
// shared codes and constants for the battery charge power controller
`default_nettype none

package bcpc_pkg;

    // charge phase codes
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_TRICKLE = 3'd1;
    localparam logic [2:0] PH_NORMAL  = 3'd2;
    localparam logic [2:0] PH_NEAR    = 3'd3;
    localparam logic [2:0] PH_FULL    = 3'd4;

    // pwm mode codes
    localparam logic [1:0] MODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_LOW  = 2'd1;
    localparam logic [1:0] MODE_HIGH = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_LOW_FREQ_PERIOD   = 3'd0;
    localparam logic [2:0] REG_HIGH_FREQ_PERIOD  = 3'd1;
    localparam logic [2:0] REG_POWER_TARGET_HIGH = 3'd2;
    localparam logic [2:0] REG_POWER_TARGET_LOW  = 3'd3;
    localparam logic [2:0] REG_INPUT_OVER        = 3'd4;
    localparam logic [2:0] REG_INPUT_UNDER       = 3'd5;
    localparam logic [2:0] REG_BATT_TRICKLE      = 3'd6;
    localparam logic [2:0] REG_BATT_NEAR_FULL    = 3'd7;

    // configuration reset values
    localparam logic [15:0] RST_POWER_TARGET_HIGH = 16'd26500;
    localparam logic [15:0] RST_POWER_TARGET_LOW  = 16'd5000;
    localparam logic [11:0] RST_INPUT_OVER        = 12'd3475;
    localparam logic [11:0] RST_INPUT_UNDER       = 12'd496;
    localparam logic [11:0] RST_BATT_TRICKLE      = 12'd2764;
    localparam logic [11:0] RST_BATT_NEAR_FULL    = 12'd3788;

    // fixed sample thresholds
    localparam logic [11:0] IDLE_INPUT_START   = 12'd912;
    localparam logic [11:0] IDLE_BATT_BLOCK    = 12'd3635;
    localparam logic [11:0] FULL_CONFIRM_LEVEL = 12'd3686;
    localparam logic [11:0] TARGET_STEP_LEVEL  = 12'd3481;
    localparam logic [11:0] CUR_OVERRANGE      = 12'd4095;

    // near-full confirm counter
    localparam logic [3:0] CONFIRM_MAX = 4'd10;
    localparam logic [3:0] CONFIRM_SAT = 4'd15;

    localparam logic [6:0] DUTY_MAX = 7'd100;

    // multiplier operand constants
    // current: ma = floor(floor(cur * 9375 / 256) / 19)
    localparam logic [22:0] K_CUR_SCALE  = 23'd9375;
    localparam logic [22:0] K_RECIP_19   = 23'd7064091;  // ceil(2^27 / 19)
    // battery: mv = floor(bat * 125 / 128)
    localparam logic [22:0] K_BATT_SCALE = 23'd125;
    localparam logic [22:0] K_MILLI      = 23'd1000;
    localparam logic [22:0] K_TRICKLE    = 23'd13;
    // percent: floor(y / 100) = floor(floor(y / 4) * ceil(2^26 / 25) / 2^26)
    localparam logic [22:0] K_RECIP_25   = 23'd2684355;

endpackage

`default_nettype wire

>>> rtl/battery_charge_power_controller_core.sv
// battery charge power controller: charge phase machine on one shared multiplier
// sequence: the calc steps, decide, the scale steps in normal charging only, done
// items: a new item is taken only once the last result is loaded, since the one
//   shared multiplier serves every scaling, product and divide step
// reset: synchronous active low; phase idle, pwm off, duty and compare zero,
//   configuration registers back to their defaults
`default_nettype none

module battery_charge_power_controller_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_adjust_due,
    input  wire logic [11:0] i_input_sample_idle,
    input  wire logic [11:0] i_input_sample_active,
    input  wire logic [11:0] i_battery_sample,
    input  wire logic [11:0] i_battery_resample,
    input  wire logic [11:0] i_current_sample,
    input  wire logic        i_pwm_off_window,
    // output channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [15:0]      o_pwm_compare,
    output logic [1:0]       o_pwm_mode,
    output logic [2:0]       o_charge_phase,
    output logic [6:0]       o_duty_percent
);
    import bcpc_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CALC   = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_SCALE  = 5'b01000,
        ST_DONE   = 5'b10000
    } t_seq_state;

    localparam logic [2:0] CALC_LAST  = 3'd6;
    localparam logic [2:0] SCALE_LAST = 3'd1;

    // configuration registers
    logic [15:0] r_low_period, r_high_period, r_tgt_high, r_tgt_low;
    logic [11:0] r_over_lim, r_under_lim, r_trickle_lim, r_near_lim;

    // sequencer and charge state
    t_seq_state  r_state, n_state;
    logic [2:0]  r_step, n_step;
    logic [2:0]  r_phase, n_phase;
    logic [1:0]  r_mode, n_mode;
    logic [6:0]  r_duty, n_duty;
    logic [3:0]  r_count, n_count;
    logic [15:0] r_compare, n_compare;
    logic        r_hf, n_hf;
    logic        r_out_valid, n_out_valid;

    // captured item
    logic        r_adjust, r_off_win;
    logic [11:0] r_in_idle, r_in_act, r_bat, r_rebat, r_cur;

    // shared multiplier and intermediate results
    logic [20:0] mul_a;
    logic [22:0] mul_b;
    logic [43:0] mul_p;
    logic [43:0] r_prod;
    logic [12:0] r_ma;
    logic [24:0] r_pw;
    logic [25:0] r_tgt;

    // step decision
    logic        d_done, d_hf;
    logic [2:0]  d_phase;
    logic [1:0]  d_mode;
    logic [6:0]  d_duty;
    logic [3:0]  d_count;
    logic [15:0] d_compare;
    logic [11:0] d_bat;
    logic [15:0] lfc;
    logic [15:0] fin_compare;
    logic        in_xfer, out_load;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_xfer     = i_in_valid && (r_state == ST_IDLE);
    assign out_load    = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign lfc         = r_prod[41:26];
    assign fin_compare = r_hf ? r_prod[41:26] : r_compare;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_period  <= '0;
            r_high_period <= '0;
            r_tgt_high    <= RST_POWER_TARGET_HIGH;
            r_tgt_low     <= RST_POWER_TARGET_LOW;
            r_over_lim    <= RST_INPUT_OVER;
            r_under_lim   <= RST_INPUT_UNDER;
            r_trickle_lim <= RST_BATT_TRICKLE;
            r_near_lim    <= RST_BATT_NEAR_FULL;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LOW_FREQ_PERIOD:   r_low_period  <= i_cfg_data;
                REG_HIGH_FREQ_PERIOD:  r_high_period <= i_cfg_data;
                REG_POWER_TARGET_HIGH: r_tgt_high    <= i_cfg_data;
                REG_POWER_TARGET_LOW:  r_tgt_low     <= i_cfg_data;
                REG_INPUT_OVER:        r_over_lim    <= i_cfg_data[11:0];
                REG_INPUT_UNDER:       r_under_lim   <= i_cfg_data[11:0];
                REG_BATT_TRICKLE:      r_trickle_lim <= i_cfg_data[11:0];
                REG_BATT_NEAR_FULL:    r_near_lim    <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // capture the item on an input transfer
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_adjust  <= i_adjust_due;
            r_in_idle <= i_input_sample_idle;
            r_in_act  <= i_input_sample_active;
            r_bat     <= i_battery_sample;
            r_rebat   <= i_battery_resample;
            r_cur     <= i_current_sample;
            r_off_win <= i_pwm_off_window;
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == ST_CALC) begin
            case (r_step)
                3'd0: begin
                    mul_a = {9'd0, r_cur};
                    mul_b = K_CUR_SCALE;
                end
                3'd1: begin
                    mul_a = {3'd0, r_prod[25:8]};
                    mul_b = K_RECIP_19;
                end
                3'd2: begin
                    mul_a = {9'd0, r_bat};
                    mul_b = K_BATT_SCALE;
                end
                3'd3: begin
                    mul_a = {9'd0, r_prod[18:7]};
                    mul_b = {10'd0, r_ma};
                end
                3'd4: begin
                    mul_a = {5'd0, (r_bat >= TARGET_STEP_LEVEL) ? r_tgt_low : r_tgt_high};
                    mul_b = K_MILLI;
                end
                3'd5: begin
                    mul_a = {5'd0, r_low_period};
                    mul_b = K_TRICKLE;
                end
                3'd6: begin
                    mul_a = {3'd0, r_prod[19:2]};
                    mul_b = K_RECIP_25;
                end
                default: ;
            endcase
        end else if (r_state == ST_SCALE) begin
            if (r_step == 3'd0) begin
                mul_a = {5'd0, r_high_period};
                mul_b = {16'd0, r_duty};
            end else begin
                mul_a = r_prod[22:2];
                mul_b = K_RECIP_25;
            end
        end
    end

    assign mul_p = {23'd0, mul_a} * {21'd0, mul_b};

    // product register and captured intermediates
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CALC || r_state == ST_SCALE) begin
            r_prod <= mul_p;
        end
        if (r_state == ST_CALC) begin
            case (r_step)
                3'd2:    r_ma  <= r_prod[39:27];
                3'd4:    r_pw  <= r_prod[24:0];
                3'd5:    r_tgt <= r_prod[25:0];
                default: ;
            endcase
        end
    end

    // next charge state for one tick
    always_comb begin
        d_done    = 1'b0;
        d_hf      = 1'b0;
        d_phase   = r_phase;
        d_mode    = r_mode;
        d_duty    = r_duty;
        d_count   = r_count;
        d_compare = r_compare;
        d_bat     = r_bat;

        // entry checks and cut-offs
        if (!r_adjust) begin
            d_done = 1'b1;
        end else if (r_phase == PH_IDLE) begin
            if (r_in_idle >= IDLE_INPUT_START) begin
                d_phase = PH_TRICKLE;
            end
            if (r_bat >= IDLE_BATT_BLOCK) begin
                d_phase = PH_IDLE;
            end
            if (d_phase == PH_IDLE) begin
                d_done = 1'b1;
            end
        end else if (r_in_act >= r_over_lim) begin
            d_compare = '0;
            d_done    = 1'b1;
        end else if (r_in_act <= r_under_lim) begin
            d_compare = '0;
            d_mode    = MODE_OFF;
            d_phase   = PH_IDLE;
            d_done    = 1'b1;
        end else if (r_phase == PH_FULL) begin
            d_done = 1'b1;
        end

        // trickle phase
        if (!d_done && d_phase == PH_TRICKLE) begin
            if (r_bat <= r_trickle_lim) begin
                if (d_mode != MODE_LOW) begin
                    d_compare = lfc;
                    d_mode    = MODE_LOW;
                end
                d_done = 1'b1;
            end else begin
                d_phase = PH_NORMAL;
            end
        end

        // near-full entry and confirm
        if (!d_done) begin
            if (r_bat >= r_near_lim && d_phase != PH_NEAR) begin
                d_compare = lfc;
                d_mode    = MODE_LOW;
                d_phase   = PH_NEAR;
            end
            if (d_phase == PH_NEAR) begin
                if (r_off_win) begin
                    d_bat = r_rebat;
                    if (d_bat >= FULL_CONFIRM_LEVEL && d_count < CONFIRM_SAT) begin
                        d_count = d_count + 4'd1;
                    end
                    if (d_count >= CONFIRM_MAX) begin
                        d_compare = '0;
                        d_mode    = MODE_OFF;
                        d_phase   = PH_FULL;
                        d_count   = '0;
                    end
                end else begin
                    d_count = '0;
                end
                if (d_bat >= r_near_lim) begin
                    d_compare = '0;
                    d_mode    = MODE_OFF;
                    d_phase   = PH_FULL;
                    d_count   = '0;
                end
                d_done = 1'b1;
            end
        end

        // normal charging: one duty step toward the power target, or down on current overrange
        if (!d_done && d_phase == PH_NORMAL) begin
            if (d_mode != MODE_HIGH) begin
                d_compare = '0;
                d_mode    = MODE_HIGH;
            end
            if (r_cur == CUR_OVERRANGE) begin
                if (d_duty != 7'd0) begin
                    d_duty = d_duty - 7'd1;
                end
            end else if ({1'b0, r_pw} < r_tgt) begin
                if (d_duty < DUTY_MAX) begin
                    d_duty = d_duty + 7'd1;
                end
            end else if ({2'b00, r_pw} >= ({1'b0, r_tgt} + 27'd1000)) begin
                if (d_duty != 7'd0) begin
                    d_duty = d_duty - 7'd1;
                end
            end
            if (d_duty > DUTY_MAX) begin
                d_duty = DUTY_MAX;
            end
            d_hf = 1'b1;
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_phase     = r_phase;
        n_mode      = r_mode;
        n_duty      = r_duty;
        n_count     = r_count;
        n_compare   = r_compare;
        n_hf        = r_hf;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_CALC;
                    n_step  = '0;
                end
            end
            ST_CALC: begin
                if (r_step == CALC_LAST) begin
                    n_state = ST_DECIDE;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            ST_DECIDE: begin
                n_phase   = d_phase;
                n_mode    = d_mode;
                n_duty    = d_duty;
                n_count   = d_count;
                n_compare = d_compare;
                n_hf      = d_hf;
                n_step    = '0;
                n_state   = d_hf ? ST_SCALE : ST_DONE;
            end
            ST_SCALE: begin
                if (r_step == SCALE_LAST) begin
                    n_state = ST_DONE;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_compare   = fin_compare;
                    n_hf        = 1'b0;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control and charge state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_phase     <= PH_IDLE;
            r_mode      <= MODE_OFF;
            r_duty      <= '0;
            r_count     <= '0;
            r_compare   <= '0;
            r_hf        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_phase     <= n_phase;
            r_mode      <= n_mode;
            r_duty      <= n_duty;
            r_count     <= n_count;
            r_compare   <= n_compare;
            r_hf        <= n_hf;
            r_out_valid <= n_out_valid;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_pwm_compare  <= fin_compare;
            o_pwm_mode     <= r_mode;
            o_charge_phase <= r_phase;
            o_duty_percent <= r_duty;
        end
    end

endmodule

`default_nettype wire

>>> rtl/bcpc_checker.sv
// port-level checks for the battery charge power controller and their bind
`default_nettype none

module bcpc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_cfg_we,
    input wire logic [2:0]  i_cfg_index,
    input wire logic [15:0] i_cfg_data,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        i_adjust_due,
    input wire logic [11:0] i_input_sample_idle,
    input wire logic [11:0] i_input_sample_active,
    input wire logic [11:0] i_battery_sample,
    input wire logic [11:0] i_battery_resample,
    input wire logic [11:0] i_current_sample,
    input wire logic        i_pwm_off_window,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [15:0] o_pwm_compare,
    input wire logic [1:0]  o_pwm_mode,
    input wire logic [2:0]  o_charge_phase,
    input wire logic [6:0]  o_duty_percent
);
    import bcpc_pkg::*;

    // an accepted item keeps the block busy for its whole evaluation
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after transfer");

    // a stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pwm_compare)
            && $stable(o_pwm_mode) && $stable(o_charge_phase)
            && $stable(o_duty_percent))
        else $error("stalled result changed");

    // result codes stay within their ranges
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pwm_mode != 2'd3) && (o_charge_phase <= PH_FULL)
            && (o_duty_percent <= DUTY_MAX))
        else $error("result code out of range");

    // idle and full never drive the pwm
    a_off_when_not_charging: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_charge_phase == PH_IDLE || o_charge_phase == PH_FULL)
            |-> (o_pwm_mode == MODE_OFF) && (o_pwm_compare == 16'd0))
        else $error("pwm active while idle or full");

endmodule

bind battery_charge_power_controller_core bcpc_checker u_bcpc_checker (.*);

`default_nettype wire

>>> verif/battery_charge_power_controller_checker.sv
// scoreboard that predicts every charger status transfer and compares it with the block
module battery_charge_power_controller_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic        i_adjust_due,
    input  wire logic [11:0] i_input_sample_idle,
    input  wire logic [11:0] i_input_sample_active,
    input  wire logic [11:0] i_battery_sample,
    input  wire logic [11:0] i_battery_resample,
    input  wire logic [11:0] i_current_sample,
    input  wire logic        i_pwm_off_window,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [15:0] i_pwm_compare,
    input  wire logic [1:0]  i_pwm_mode,
    input  wire logic [2:0]  i_charge_phase,
    input  wire logic [6:0]  i_duty_percent,
    output int               o_fault_count,
    output int               o_pending
);

    import bcpc_pkg::*;

    typedef struct packed {
        logic [15:0] compare;
        logic [1:0]  mode;
        logic [2:0]  phase;
        logic [6:0]  duty;
    } charger_status_t;

    // local copy of the configuration registers
    logic [15:0] low_period_q, high_period_q, target_high_q, target_low_q;
    logic [11:0] over_limit_q, under_limit_q, trickle_limit_q, near_full_limit_q;

    // predicted charger state
    logic [2:0]  phase_q;
    logic [1:0]  mode_q;
    logic [6:0]  duty_q;
    logic [3:0]  confirm_q;
    logic [15:0] compare_q;

    charger_status_t expected_status[$];
    charger_status_t want;
    int fault_total = 0;
    int results_seen = 0;

    assign o_fault_count = fault_total;

    task automatic log_mismatch(input string msg);
        $display("MISMATCH %s", msg);
        fault_total++;
    endtask

    // 13 percent of the low-frequency period
    function automatic logic [15:0] trickle_compare(input logic [15:0] period);
        logic [31:0] prod;
        prod = {16'd0, period} * 32'd13 / 32'd100;
        return prod[15:0];
    endfunction

    task automatic finish_charge();
        compare_q = 16'd0;
        mode_q    = MODE_OFF;
        phase_q   = PH_FULL;
        confirm_q = 4'd0;
    endtask

    // one adjustment tick of the charge phase machine
    task automatic advance_charger();
        logic [11:0] batt;
        logic [15:0] target;
        logic [63:0] milliamps, millivolts, power;
        logic [31:0] prod;
        batt = i_battery_sample;

        // idle start check, or input cut-offs while charging
        if (phase_q == PH_IDLE) begin
            if (i_input_sample_idle >= IDLE_INPUT_START) phase_q = PH_TRICKLE;
            if (batt >= IDLE_BATT_BLOCK) phase_q = PH_IDLE;
            if (phase_q == PH_IDLE) return;
        end else begin
            if (i_input_sample_active >= over_limit_q) begin
                compare_q = 16'd0;
                return;
            end
            if (i_input_sample_active <= under_limit_q) begin
                compare_q = 16'd0;
                mode_q    = MODE_OFF;
                phase_q   = PH_IDLE;
                return;
            end
            if (phase_q == PH_FULL) return;
        end

        // trickle stays while the battery is low
        if (phase_q == PH_TRICKLE) begin
            if (batt <= trickle_limit_q) begin
                if (mode_q != MODE_LOW) begin
                    compare_q = trickle_compare(low_period_q);
                    mode_q    = MODE_LOW;
                end
                return;
            end
            phase_q = PH_NORMAL;
        end

        if (batt >= near_full_limit_q && phase_q != PH_NEAR) begin
            compare_q = trickle_compare(low_period_q);
            mode_q    = MODE_LOW;
            phase_q   = PH_NEAR;
        end

        // near-full confirm counting in the off window
        if (phase_q == PH_NEAR) begin
            if (i_pwm_off_window) begin
                batt = i_battery_resample;
                if (batt >= FULL_CONFIRM_LEVEL && confirm_q < CONFIRM_SAT)
                    confirm_q = confirm_q + 4'd1;
                if (confirm_q >= CONFIRM_MAX) finish_charge();
            end else begin
                confirm_q = 4'd0;
            end
            if (batt >= near_full_limit_q) finish_charge();
            return;
        end

        if (phase_q != PH_NORMAL) return;

        if (mode_q != MODE_HIGH) begin
            compare_q = 16'd0;
            mode_q    = MODE_HIGH;
        end

        // power tracking step
        target     = (batt >= TARGET_STEP_LEVEL) ? target_low_q : target_high_q;
        milliamps  = {52'd0, i_current_sample} * 64'd600000 / 64'd4096 / 64'd76;
        millivolts = {52'd0, batt} * 64'd4000 / 64'd4096;
        power      = millivolts * milliamps / 64'd1000;
        if (i_current_sample == CUR_OVERRANGE) begin
            if (duty_q != 7'd0) duty_q = duty_q - 7'd1;
        end else if (power < {48'd0, target}) begin
            if (duty_q < DUTY_MAX) duty_q = duty_q + 7'd1;
        end else if (power > {48'd0, target}) begin
            if (duty_q != 7'd0) duty_q = duty_q - 7'd1;
        end
        prod      = {16'd0, high_period_q} * {25'd0, duty_q} / 32'd100;
        compare_q = prod[15:0];
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            low_period_q      = 16'd0;
            high_period_q     = 16'd0;
            target_high_q     = RST_POWER_TARGET_HIGH;
            target_low_q      = RST_POWER_TARGET_LOW;
            over_limit_q      = RST_INPUT_OVER;
            under_limit_q     = RST_INPUT_UNDER;
            trickle_limit_q   = RST_BATT_TRICKLE;
            near_full_limit_q = RST_BATT_NEAR_FULL;
            phase_q   = PH_IDLE;
            mode_q    = MODE_OFF;
            duty_q    = 7'd0;
            confirm_q = 4'd0;
            compare_q = 16'd0;
            expected_status.delete();
        end else begin
            // result transfer against the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                results_seen++;
                if (expected_status.size() == 0) begin
                    log_mismatch($sformatf("result %0d arrived with nothing pending",
                                           results_seen));
                end else begin
                    want = expected_status.pop_front();
                    if (i_pwm_compare !== want.compare)
                        log_mismatch($sformatf("result %0d pwm_compare %0d, expected %0d",
                                               results_seen, i_pwm_compare, want.compare));
                    if (i_pwm_mode !== want.mode)
                        log_mismatch($sformatf("result %0d pwm_mode %0d, expected %0d",
                                               results_seen, i_pwm_mode, want.mode));
                    if (i_charge_phase !== want.phase)
                        log_mismatch($sformatf("result %0d charge_phase %0d, expected %0d",
                                               results_seen, i_charge_phase, want.phase));
                    if (i_duty_percent !== want.duty)
                        log_mismatch($sformatf("result %0d duty_percent %0d, expected %0d",
                                               results_seen, i_duty_percent, want.duty));
                end
            end

            // register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_LOW_FREQ_PERIOD:   low_period_q      = i_cfg_data;
                    REG_HIGH_FREQ_PERIOD:  high_period_q     = i_cfg_data;
                    REG_POWER_TARGET_HIGH: target_high_q     = i_cfg_data;
                    REG_POWER_TARGET_LOW:  target_low_q      = i_cfg_data;
                    REG_INPUT_OVER:        over_limit_q      = i_cfg_data[11:0];
                    REG_INPUT_UNDER:       under_limit_q     = i_cfg_data[11:0];
                    REG_BATT_TRICKLE:      trickle_limit_q   = i_cfg_data[11:0];
                    REG_BATT_NEAR_FULL:    near_full_limit_q = i_cfg_data[11:0];
                    default: ;
                endcase
            end

            // sample transfer: step the prediction
            if (i_in_valid && !i_in_stall) begin
                if (i_adjust_due) advance_charger();
                expected_status.push_back({compare_q, mode_q, phase_q, duty_q});
            end
        end
        o_pending <= expected_status.size();
    end

endmodule

>>> verif/tb_battery_charge_power_controller_core.sv
// testbench top: clock, reset, register setup, sample stimulus and final verdict
module tb_battery_charge_power_controller_core;

    import bcpc_pkg::*;

    localparam int QUIET_LIMIT = 4000;

    typedef enum int {
        K_START, K_TRICKLE, K_NORMAL, K_NEAR, K_CONFIRM, K_OVER, K_UNDER, K_NOISE, K_NOTICK
    } adc_kind_e;

    typedef enum int {
        SET_BASE, SET_WIDE, SET_ZERO, SET_MAX, SET_SANE, SET_WILD
    } reg_set_e;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = REG_LOW_FREQ_PERIOD;
    logic [15:0] cfg_data = 16'd0;
    logic        in_valid = 1'b0;
    logic        adjust_due = 1'b0;
    logic [11:0] input_idle = 12'd0;
    logic [11:0] input_active = 12'd0;
    logic [11:0] battery = 12'd0;
    logic [11:0] battery_re = 12'd0;
    logic [11:0] current = 12'd0;
    logic        off_window = 1'b0;
    logic        out_stall = 1'b0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [15:0] o_pwm_compare;
    logic [1:0]  o_pwm_mode;
    logic [2:0]  o_charge_phase;
    logic [6:0]  o_duty_percent;

    int fault_count;
    int pending;
    int send_idle_pct = 24;
    int recv_stall_pct = 77;
    int items_sent = 0;
    int quiet_cycles = 0;
    int cfg_now[8];

    always #1 clk = ~clk;

    battery_charge_power_controller_core dut (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_cfg_we              (cfg_we),
        .i_cfg_index           (cfg_index),
        .i_cfg_data            (cfg_data),
        .i_in_valid            (in_valid),
        .o_in_stall            (o_in_stall),
        .i_adjust_due          (adjust_due),
        .i_input_sample_idle   (input_idle),
        .i_input_sample_active (input_active),
        .i_battery_sample      (battery),
        .i_battery_resample    (battery_re),
        .i_current_sample      (current),
        .i_pwm_off_window      (off_window),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (out_stall),
        .o_pwm_compare         (o_pwm_compare),
        .o_pwm_mode            (o_pwm_mode),
        .o_charge_phase        (o_charge_phase),
        .o_duty_percent        (o_duty_percent)
    );

    battery_charge_power_controller_checker status_check (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_cfg_we              (cfg_we),
        .i_cfg_index           (cfg_index),
        .i_cfg_data            (cfg_data),
        .i_in_valid            (in_valid),
        .i_in_stall            (o_in_stall),
        .i_adjust_due          (adjust_due),
        .i_input_sample_idle   (input_idle),
        .i_input_sample_active (input_active),
        .i_battery_sample      (battery),
        .i_battery_resample    (battery_re),
        .i_current_sample      (current),
        .i_pwm_off_window      (off_window),
        .i_out_valid           (o_out_valid),
        .i_out_stall           (out_stall),
        .i_pwm_compare         (o_pwm_compare),
        .i_pwm_mode            (o_pwm_mode),
        .i_charge_phase        (o_charge_phase),
        .i_duty_percent        (o_duty_percent),
        .o_fault_count         (fault_count),
        .o_pending             (pending)
    );

    // random back-pressure on the status side
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // random sample value in a range, any value when the range is empty
    function automatic logic [11:0] pick(input int lo, input int hi);
        if (lo < 0) lo = 0;
        if (hi > 4095) hi = 4095;
        if (hi < lo) return 12'($urandom_range(4095));
        return 12'($urandom_range(hi, lo));
    endfunction

    // write all registers from one setting, block idle
    task automatic program_regs(input reg_set_e setting);
        logic [15:0] v [8];
        case (setting)
            SET_BASE: v = '{16'd1000, 16'd40000, RST_POWER_TARGET_HIGH, RST_POWER_TARGET_LOW,
                            {4'd0, RST_INPUT_OVER}, {4'd0, RST_INPUT_UNDER},
                            {4'd0, RST_BATT_TRICKLE}, {4'd0, RST_BATT_NEAR_FULL}};
            SET_WIDE: v = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0,
                            16'd4095, 16'd0, 16'd1000, 16'd3900};
            SET_ZERO: v = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
            SET_MAX:  v = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                            16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
            SET_SANE: v = '{16'($urandom_range(65535)), 16'($urandom_range(65535)),
                            16'($urandom_range(30000)), 16'($urandom_range(30000)),
                            16'($urandom_range(4095, 3000)), 16'($urandom_range(900)),
                            16'($urandom_range(3000, 1000)), 16'($urandom_range(4000, 3300))};
            SET_WILD: begin
                foreach (v[i]) v[i] = 16'($urandom());
            end
            default: ;
        endcase
        for (int i = REG_LOW_FREQ_PERIOD; i <= REG_BATT_NEAR_FULL; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= v[i];
            cfg_now[i] = (i >= REG_INPUT_OVER) ? int'(v[i][11:0]) : int'(v[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // one sample transfer, with random idle cycles ahead of it
    task automatic put(input logic adj, input logic [11:0] idle_s, input logic [11:0] act_s,
                       input logic [11:0] bat_s, input logic [11:0] rebat_s,
                       input logic [11:0] cur_s, input logic offw);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        adjust_due   <= adj;
        input_idle   <= idle_s;
        input_active <= act_s;
        battery      <= bat_s;
        battery_re   <= rebat_s;
        current      <= cur_s;
        off_window   <= offw;
        @(posedge clk);
        while (o_in_stall) @(posedge clk);
        items_sent++;
    endtask

    // build a sample aimed at one part of a charge cycle, sometimes replaced by noise
    task automatic send_kind(input adc_kind_e kind_in);
        adc_kind_e kind;
        int roll;
        logic adj, offw;
        logic [11:0] idle_s, act_s, bat_s, rebat_s, cur_s;
        roll = $urandom_range(99);
        kind = kind_in;
        if (roll < 4) kind = K_NOTICK;
        else if (roll < 8) kind = K_OVER;
        else if (roll < 11) kind = K_NOISE;
        adj     = 1'b1;
        offw    = 1'($urandom_range(1));
        idle_s  = 12'($urandom_range(4095));
        act_s   = pick(cfg_now[REG_INPUT_UNDER] + 1, cfg_now[REG_INPUT_OVER] - 1);
        bat_s   = 12'($urandom_range(4095));
        rebat_s = 12'($urandom_range(4095));
        cur_s   = 12'($urandom_range(4095));
        case (kind)
            K_START: begin
                idle_s = pick(IDLE_INPUT_START, 4095);
                if ($urandom_range(9) != 0) bat_s = pick(0, IDLE_BATT_BLOCK - 1);
            end
            K_TRICKLE: bat_s = pick(0, cfg_now[REG_BATT_TRICKLE]);
            K_NORMAL: begin
                bat_s = pick(cfg_now[REG_BATT_TRICKLE] + 1, cfg_now[REG_BATT_NEAR_FULL] - 1);
                roll = $urandom_range(9);
                if (roll == 0) cur_s = CUR_OVERRANGE;
                else if (roll == 1) cur_s = 12'd0;
                else cur_s = pick(0, CUR_OVERRANGE - 1);
            end
            K_NEAR: bat_s = pick(cfg_now[REG_BATT_NEAR_FULL], 4095);
            K_CONFIRM: begin
                bat_s = pick(cfg_now[REG_BATT_TRICKLE] + 1, cfg_now[REG_BATT_NEAR_FULL] - 1);
                offw  = ($urandom_range(9) != 0);
                if ($urandom_range(9) != 0)
                    rebat_s = pick(FULL_CONFIRM_LEVEL, cfg_now[REG_BATT_NEAR_FULL] - 1);
            end
            K_OVER:   act_s = pick(cfg_now[REG_INPUT_OVER], 4095);
            K_UNDER:  act_s = pick(0, cfg_now[REG_INPUT_UNDER]);
            K_NOISE: begin
                act_s = 12'($urandom_range(4095));
                adj   = 1'($urandom_range(1));
            end
            K_NOTICK: begin
                act_s = 12'($urandom_range(4095));
                adj   = 1'b0;
            end
            default: ;
        endcase
        put(adj, idle_s, act_s, bat_s, rebat_s, cur_s, offw);
    endtask

    // drop valid and let every pending status drain before touching registers
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    initial begin
        int goal;
        reg_set_e setting;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        program_regs(SET_BASE);

        // directed walk through one full charge cycle
        put(1'b0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1);
        put(1'b1, IDLE_INPUT_START - 12'd1, 12'd2000, 12'd1000, 12'd0, 12'd0, 1'b0);
        put(1'b1, 12'hFFF, 12'd2000, IDLE_BATT_BLOCK, 12'd0, 12'd0, 1'b0);
        put(1'b1, IDLE_INPUT_START, 12'd2000, RST_BATT_TRICKLE, 12'd0, 12'd100, 1'b0);
        put(1'b1, 12'd0, 12'd2000, 12'd0, 12'd0, 12'd0, 1'b0);
        put(1'b1, 12'd0, RST_INPUT_OVER, 12'd1000, 12'd0, 12'd0, 1'b0);
        put(1'b1, 12'd0, 12'd2000, RST_BATT_TRICKLE + 12'd1, 12'd0, 12'd0, 1'b0);
        put(1'b1, 12'd0, 12'd2000, 12'd3000, 12'd0, CUR_OVERRANGE, 1'b0);
        put(1'b1, 12'd0, RST_INPUT_OVER - 12'd1, TARGET_STEP_LEVEL - 12'd1, 12'd0,
            CUR_OVERRANGE - 12'd1, 1'b0);
        put(1'b1, 12'd0, RST_INPUT_UNDER + 12'd1, TARGET_STEP_LEVEL, 12'd0, 12'd1000, 1'b0);
        put(1'b1, 12'd0, 12'd2000, RST_BATT_NEAR_FULL, 12'd3000, 12'd0, 1'b0);
        put(1'b1, 12'd0, 12'd2000, 12'd3700, FULL_CONFIRM_LEVEL, 12'd0, 1'b1);
        put(1'b1, 12'd0, 12'd2000, 12'd3700, FULL_CONFIRM_LEVEL, 12'd0, 1'b0);
        for (int k = 0; k < 10; k++)
            put(1'b1, 12'd0, 12'd2000, 12'd3700,
                k[0] ? FULL_CONFIRM_LEVEL : RST_BATT_NEAR_FULL - 12'd1, 12'd0, 1'b1);
        put(1'b1, 12'd0, 12'hFFF, 12'd3700, 12'd0, 12'd0, 1'b0);
        put(1'b1, 12'd0, RST_INPUT_UNDER, 12'd3700, 12'd0, 12'd0, 1'b0);
        put(1'b1, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0);
        settle();

        // random charge cycles over several register settings
        for (int p = 0; p < 7; p++) begin
            if (p < 2) begin
                send_idle_pct  = 24;
                recv_stall_pct = 77;
            end else if (p < 5) begin
                send_idle_pct  = 77;
                recv_stall_pct = 24;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            case (p)
                0:       setting = SET_BASE;
                1:       setting = SET_WIDE;
                2:       setting = SET_ZERO;
                3:       setting = SET_MAX;
                6:       setting = SET_WILD;
                default: setting = SET_SANE;
            endcase
            program_regs(setting);
            goal = items_sent + ((p == 2 || p == 3) ? 40 : (p == 6) ? 100 : 180);
            while (items_sent < goal) begin
                if ($urandom_range(9) == 0) begin
                    send_kind(K_NOISE);
                end else begin
                    send_kind(K_START);
                    repeat ($urandom_range(4)) send_kind(K_TRICKLE);
                    repeat ($urandom_range(30, 3)) send_kind(K_NORMAL);
                    send_kind(K_NEAR);
                    repeat ($urandom_range(14, 6)) send_kind(K_CONFIRM);
                    send_kind(K_UNDER);
                end
            end
            settle();
        end

        if (fault_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
